@@ design/pcd_pkg.sv @@
// Shared constants, payload types and cell control types for the page cache directory.
package pcd_pkg;

  localparam int SLOTS      = 16;
  localparam int FILES      = 4;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int RANK_W     = SLOT_W;
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int FIDX_W     = (FILES > 1) ? $clog2(FILES) : 1;
  localparam int OP_W       = 2;
  localparam int FILE_ID_W  = 2;
  localparam int PAGE_W     = 24;
  localparam int COUNT_W    = 25;
  localparam int SLOT_OUT_W = 4;

  typedef enum logic [OP_W-1:0] {
    OP_OPEN  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_CLOSE = 2'd3
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]      operation;
    logic [FILE_ID_W-1:0] file_id;
    logic [PAGE_W-1:0]    page_id;
    logic [COUNT_W-1:0]   page_count;
  } req_t;

  typedef struct packed {
    logic                  status;
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic [COUNT_W-1:0]    end_page;
  } rsp_t;

  // what every cell does this cycle
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOOK,
    ACT_TOUCH,
    ACT_DROP,
    ACT_SWEEP
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD,
    ST_SWEEP
  } state_t;

  typedef struct packed {
    act_t              act;
    logic [FIDX_W-1:0] file;
    logic [PAGE_W-1:0] page;
    logic              use_match;
    logic              use_empty;
    logic              pick_valid;
    logic [RANK_W-1:0] pick_rank;
    logic [RANK_W-1:0] new_rank;
  } cell_ctl_t;

  typedef struct packed {
    logic empty_seen;
    logic close_seen;
  } chain_t;

  typedef struct packed {
    logic              valid;
    logic              matched;
    logic              empty_vict;
    logic              pick;
    logic              pick_valid;
    logic [RANK_W-1:0] pick_rank;
  } cell_stat_t;

endpackage

@@ design/pcd_if.sv @@
// Request and response channel interfaces of the page cache directory.
interface pcd_req_if import pcd_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pcd_rsp_if import pcd_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/pcd_cell.sv @@
// One directory slot: tag, valid bit, recency rank and lookup flags.
module pcd_cell import pcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctl_t  ctl,
  input  chain_t     chain_in,
  output chain_t     chain_out,
  output cell_stat_t stat
);

  logic              valid;
  logic [FIDX_W-1:0] file;
  logic [PAGE_W-1:0] page;
  logic [RANK_W-1:0] rank;
  logic              matched;
  logic              empty_vict;
  logic              oldest_vict;

  logic hit_now;
  logic close_hit;
  logic kill;
  logic sel;
  logic pick;
  logic shift_down;

  always_comb begin
    hit_now   = valid && (file == ctl.file) && (page == ctl.page);
    close_hit = valid && (file == ctl.file);
    // first cell of the file along the chain gets emptied this cycle
    kill      = close_hit && !chain_in.close_seen;
    chain_out.empty_seen = chain_in.empty_seen || !valid;
    chain_out.close_seen = chain_in.close_seen || close_hit;
    sel  = ctl.use_match ? matched : (ctl.use_empty ? empty_vict : oldest_vict);
    pick = (ctl.act == ACT_SWEEP) ? kill : sel;
    shift_down = valid && !pick && ctl.pick_valid && (rank > ctl.pick_rank);
    stat.valid      = valid;
    stat.matched    = matched;
    stat.empty_vict = empty_vict;
    stat.pick       = pick;
    stat.pick_valid = pick && valid;
    stat.pick_rank  = pick ? rank : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= 1'b0;
      rank        <= '0;
      matched     <= 1'b0;
      empty_vict  <= 1'b0;
      oldest_vict <= 1'b0;
    end else begin
      case (ctl.act)
        ACT_LOOK: begin
          matched     <= hit_now;
          empty_vict  <= !valid && !chain_in.empty_seen;
          oldest_vict <= valid && (rank == '0);
        end
        ACT_TOUCH: begin
          if (pick) begin
            valid <= 1'b1;
            rank  <= ctl.new_rank;
          end else if (shift_down) begin
            rank <= rank - RANK_W'(1);
          end
        end
        ACT_DROP, ACT_SWEEP: begin
          if (pick) begin
            valid <= 1'b0;
            rank  <= '0;
          end else if (shift_down) begin
            rank <= rank - RANK_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // tag storage, qualified by valid
  always_ff @(posedge clk) begin
    case (ctl.act)
      ACT_TOUCH: begin
        if (pick && !ctl.use_match) begin
          file <= ctl.file;
          page <= ctl.page;
        end
      end
      ACT_DROP, ACT_SWEEP: begin
        if (pick) begin
          file <= '0;
          page <= '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ design/page_cache_directory_lru.sv @@
// Top level of the page cache directory: sequencer, end page table and the chain of slot cells.
//
// Fully associative tag directory for a shared page read cache with exact LRU replacement.
// Each request beat (open, read, write, close) yields exactly one response beat. Open, read
// and write pass through a lookup state in which every slot cell compares its tag and flags
// the first empty slot and the oldest slot, then an update state that, for read and write,
// moves the recency ranks; a new request is taken in that update state, so it overlaps the
// end of the previous one. Close empties the file's cached slots one per cycle along the
// cell chain. The response sits in an output register, so a waiting response stalls only
// the update state or the final sweep step.
module page_cache_directory_lru import pcd_pkg::*; (
  input logic       clk,
  input logic       rst,
  pcd_req_if.sink   req,
  pcd_rsp_if.source rsp
);

  state_t             state;
  state_t             state_next;
  op_t                cmd_op;
  logic [FIDX_W-1:0]  cmd_file;
  logic [PAGE_W-1:0]  cmd_page;
  logic [COUNT_W-1:0] cmd_count;
  logic               inval;
  logic [CNT_W-1:0]   nvalid;
  logic [COUNT_W-1:0] end_page [FILES];
  logic               ov;
  rsp_t               rsp_q;

  cell_ctl_t          ctl;
  chain_t             chain [SLOTS+1];
  cell_stat_t         stat [SLOTS];

  logic               accept;
  logic               out_free;
  logic               load;
  rsp_t               rsp_next;
  logic               ep_we;
  logic [COUNT_W-1:0] ep_wd;
  logic               nv_inc;
  logic               nv_dec;
  logic [COUNT_W-1:0] ep_cur;
  logic [COUNT_W-1:0] page_ext;
  logic               any_match;
  logic               any_empty;
  logic               any_pick_valid;
  logic [RANK_W-1:0]  pick_rank;
  logic [SLOT_W-1:0]  pick_idx;
  logic [SLOTS-1:0]   pick_vec;
  logic [SLOTS-1:0]   valid_vec;

  assign chain[0] = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    pcd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .stat      (stat[i])
    );
  end

  always_comb begin
    any_match      = 1'b0;
    any_empty      = 1'b0;
    any_pick_valid = 1'b0;
    pick_rank      = '0;
    pick_idx       = '0;
    for (int i = 0; i < SLOTS; i++) begin
      any_match      = any_match | stat[i].matched;
      any_empty      = any_empty | stat[i].empty_vict;
      any_pick_valid = any_pick_valid | stat[i].pick_valid;
      pick_rank      = pick_rank | stat[i].pick_rank;
      pick_idx       = pick_idx | (stat[i].pick ? SLOT_W'(i) : '0);
      pick_vec[i]    = stat[i].pick;
      valid_vec[i]   = stat[i].valid;
    end
  end

  assign out_free  = !ov || rsp.ready;
  assign req.ready = (state == ST_IDLE) || ((state == ST_UPD) && out_free);
  assign accept    = req.valid && req.ready;
  assign ep_cur    = end_page[cmd_file];
  assign page_ext  = {1'b0, cmd_page};
  assign rsp.valid = ov;
  assign rsp.data  = rsp_q;

  always_comb begin
    state_next     = state;
    load           = 1'b0;
    rsp_next       = '0;
    ep_we          = 1'b0;
    ep_wd          = '0;
    nv_inc         = 1'b0;
    nv_dec         = 1'b0;
    ctl.act        = ACT_NONE;
    ctl.file       = cmd_file;
    ctl.page       = cmd_page;
    ctl.use_match  = any_match || (cmd_op == OP_WRITE);
    ctl.use_empty  = any_empty;
    ctl.pick_valid = any_pick_valid;
    ctl.pick_rank  = pick_rank;
    ctl.new_rank   = any_pick_valid ? RANK_W'(nvalid - CNT_W'(1)) : RANK_W'(nvalid);
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        ctl.act    = ACT_LOOK;
        state_next = (cmd_op == OP_CLOSE) ? ST_SWEEP : ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          load              = 1'b1;
          rsp_next.end_page = ep_cur;
          case (cmd_op)
            OP_OPEN: begin
              ep_we             = 1'b1;
              ep_wd             = cmd_count;
              rsp_next.end_page = cmd_count;
            end
            OP_READ: begin
              if (inval) begin
                rsp_next.status = 1'b1;
              end else begin
                ctl.act       = ACT_TOUCH;
                nv_inc        = !any_pick_valid;
                rsp_next.hit  = any_match;
                rsp_next.slot = SLOT_OUT_W'(pick_idx);
              end
            end
            OP_WRITE: begin
              if (any_match) begin
                ctl.act       = ACT_DROP;
                nv_dec        = 1'b1;
                rsp_next.hit  = 1'b1;
                rsp_next.slot = SLOT_OUT_W'(pick_idx);
              end
              // inval holds page >= end page here as well
              if (inval) begin
                ep_we             = 1'b1;
                ep_wd             = page_ext + COUNT_W'(1);
                rsp_next.end_page = page_ext + COUNT_W'(1);
              end
            end
            default: begin
            end
          endcase
          state_next = req.valid ? ST_LOOK : ST_IDLE;
        end
      end
      ST_SWEEP: begin
        ctl.act = ACT_SWEEP;
        if (chain[SLOTS].close_seen) begin
          nv_dec = 1'b1;
        end else if (out_free) begin
          load       = 1'b1;
          ep_we      = 1'b1;
          ep_wd      = '0;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      ov     <= 1'b0;
      nvalid <= '0;
      for (int i = 0; i < FILES; i++) begin
        end_page[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (load) begin
        ov <= 1'b1;
      end else if (rsp.ready) begin
        ov <= 1'b0;
      end
      if (nv_inc) begin
        nvalid <= nvalid + CNT_W'(1);
      end else if (nv_dec) begin
        nvalid <= nvalid - CNT_W'(1);
      end
      if (ep_we) begin
        end_page[cmd_file] <= ep_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_op    <= op_t'(req.data.operation);
      cmd_file  <= FIDX_W'(req.data.file_id % FILES);
      cmd_page  <= req.data.page_id;
      cmd_count <= req.data.page_count;
    end
    if (state == ST_LOOK) begin
      inval <= page_ext >= ep_cur;
    end
    if (load) begin
      rsp_q <= rsp_next;
    end
  end

  // at most one cell acts as the updated slot
  a_pick_onehot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD || state == ST_SWEEP) |-> $onehot0(pick_vec))
    else $error("more than one slot picked");

  a_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(nvalid))
    else $error("valid count out of step with slot valid bits");

  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_LOOK))
    else $error("accepted beat not followed by lookup");

  a_sweep_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP && state_next == ST_IDLE) |-> !chain[SLOTS].close_seen)
    else $error("close finished with slots of the file left");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the page cache directory: driver, monitor and LRU directory model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pcd_pkg::*;

  typedef struct {
    req_t beat;
    int   phase;
    bit   hold;   // wait for all responses before presenting this beat
  } stim_t;

  logic clk = 1'b0;
  logic rst;

  pcd_req_if req_if ();
  pcd_rsp_if rsp_if ();

  page_cache_directory_lru u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #1 clk = ~clk;

  stim_t pending [$];
  rsp_t  expected_rsp [$];
  int    mism_cnt  = 0;
  int    cur_phase = 0;

  // directory model
  bit                 tag_valid [SLOTS];
  int                 tag_file  [SLOTS];
  bit [PAGE_W-1:0]    tag_page  [SLOTS];
  int                 tag_rank  [SLOTS];
  bit [COUNT_W-1:0]   end_tbl   [FILES];

  function automatic int idle_pct(int ph, bit rx);
    case (ph)
      0:       return rx ? 59 : 29;
      1:       return rx ? 29 : 59;
      default: return 0;
    endcase
  endfunction

  function automatic int find_page(int f, bit [PAGE_W-1:0] pg);
    for (int i = 0; i < SLOTS; i++)
      if (tag_valid[i] && tag_file[i] == f && tag_page[i] == pg) return i;
    return -1;
  endfunction

  // empty a slot and close the gap it leaves in the recency order
  function automatic void drop_slot(int s);
    if (tag_valid[s]) begin
      for (int j = 0; j < SLOTS; j++)
        if (j != s && tag_valid[j] && tag_rank[j] > tag_rank[s]) tag_rank[j]--;
    end
    tag_valid[s] = 1'b0;
    tag_file[s]  = 0;
    tag_page[s]  = '0;
    tag_rank[s]  = 0;
  endfunction

  function automatic rsp_t predict_access(req_t r);
    rsp_t             o;
    int               f;
    int               victim;
    int               nvalid;
    int               old_rank;
    bit [COUNT_W-1:0] pg;
    o  = '0;
    f  = int'(r.file_id) % FILES;
    pg = {1'b0, r.page_id};
    case (op_t'(r.operation))
      OP_OPEN: end_tbl[f] = r.page_count;
      OP_READ: begin
        if (pg >= end_tbl[f]) begin
          o.status = 1'b1;
        end else begin
          victim = find_page(f, r.page_id);
          if (victim >= 0) begin
            o.hit = 1'b1;
          end else begin
            for (int i = 0; i < SLOTS; i++)
              if (!tag_valid[i] && victim < 0) victim = i;
            // directory full: evict the least recent slot
            if (victim < 0)
              for (int i = 0; i < SLOTS; i++)
                if (tag_rank[i] == 0 && victim < 0) victim = i;
            tag_file[victim] = f;
            tag_page[victim] = r.page_id;
          end
          o.slot = victim[SLOT_OUT_W-1:0];
          nvalid = 0;
          for (int i = 0; i < SLOTS; i++) nvalid += int'(tag_valid[i]);
          if (tag_valid[victim]) begin
            old_rank = tag_rank[victim];
            for (int j = 0; j < SLOTS; j++)
              if (tag_valid[j] && tag_rank[j] > old_rank) tag_rank[j]--;
            tag_rank[victim] = nvalid - 1;
          end else begin
            tag_valid[victim] = 1'b1;
            tag_rank[victim]  = nvalid;
          end
        end
      end
      OP_WRITE: begin
        victim = find_page(f, r.page_id);
        if (victim >= 0) begin
          o.hit  = 1'b1;
          o.slot = victim[SLOT_OUT_W-1:0];
          drop_slot(victim);
        end
        if (pg >= end_tbl[f]) end_tbl[f] = pg + 1'b1;
      end
      default: begin
        for (int i = 0; i < SLOTS; i++)
          if (tag_valid[i] && tag_file[i] == f) drop_slot(i);
        end_tbl[f] = '0;
      end
    endcase
    o.end_page = end_tbl[f];
    return o;
  endfunction

  task automatic add_beat(op_t op, int f, int unsigned pg, int unsigned cnt, int ph, bit hold);
    stim_t s;
    s.beat.operation  = op;
    s.beat.file_id    = f[FILE_ID_W-1:0];
    s.beat.page_id    = pg[PAGE_W-1:0];
    s.beat.page_count = cnt[COUNT_W-1:0];
    s.phase           = ph;
    s.hold            = hold;
    pending.push_back(s);
  endtask

  // request driver
  always @(posedge clk) begin
    stim_t nxt;
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) expected_rsp.push_back(predict_access(req_if.data));
      if (!req_if.valid || req_if.ready) begin
        if (pending.size() != 0 && (!pending[0].hold || expected_rsp.size() == 0) &&
            $urandom_range(0, 99) >= idle_pct(pending[0].phase, 1'b0)) begin
          nxt = pending.pop_front();
          req_if.valid <= 1'b1;
          req_if.data  <= nxt.beat;
          cur_phase    <= nxt.phase;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsp.size() == 0) begin
          mism_cnt++;
          if (mism_cnt <= 10)
            $display("unexpected response beat: status=%0d hit=%0d slot=%0d end=%0d",
                     rsp_if.data.status, rsp_if.data.hit, rsp_if.data.slot,
                     rsp_if.data.end_page);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_if.data.status !== want.status || rsp_if.data.hit !== want.hit ||
              rsp_if.data.slot !== want.slot || rsp_if.data.end_page !== want.end_page) begin
            mism_cnt++;
            if (mism_cnt <= 10)
              $display("mismatch: exp status=%0d hit=%0d slot=%0d end=%0d, got %0d %0d %0d %0d",
                       want.status, want.hit, want.slot, want.end_page,
                       rsp_if.data.status, rsp_if.data.hit, rsp_if.data.slot,
                       rsp_if.data.end_page);
          end
        end
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= idle_pct(cur_phase, 1'b1));
    end
  end

  initial begin
    int unsigned roll;
    int unsigned pg;
    int unsigned cnt;
    int          f;
    op_t         op;
    rst = 1'b1;

    // directed: closed file, range edges, hits, invalidation, reopen, close with slots
    add_beat(OP_CLOSE, 0, 0,          0,          0, 1'b0);
    add_beat(OP_READ,  0, 0,          0,          0, 1'b0);
    add_beat(OP_OPEN,  0, 0,          25'h1000000, 0, 1'b0);
    add_beat(OP_READ,  0, 0,          0,          0, 1'b0);
    add_beat(OP_READ,  0, 0,          0,          0, 1'b0);
    add_beat(OP_READ,  0, 24'hFFFFFF, 0,          0, 1'b0);
    add_beat(OP_OPEN,  1, 0,          10,         0, 1'b0);
    add_beat(OP_READ,  1, 9,          0,          0, 1'b0);
    add_beat(OP_READ,  1, 10,         0,          0, 1'b0);
    add_beat(OP_WRITE, 1, 9,          0,          0, 1'b0);
    add_beat(OP_WRITE, 1, 100,        0,          0, 1'b0);
    add_beat(OP_OPEN,  2, 0,          25'h0FFFFFF, 0, 1'b0);
    add_beat(OP_READ,  2, 24'hAAAAAA, 0,          0, 1'b0);
    add_beat(OP_READ,  2, 24'h555555, 0,          0, 1'b0);
    add_beat(OP_WRITE, 3, 24'hFFFFFF, 0,          0, 1'b0);
    add_beat(OP_READ,  3, 24'hFFFFFE, 0,          0, 1'b0);
    add_beat(OP_OPEN,  0, 0,          5,          0, 1'b0);
    add_beat(OP_READ,  0, 0,          0,          0, 1'b0);
    add_beat(OP_READ,  0, 24'hFFFFFF, 0,          0, 1'b0);
    add_beat(OP_CLOSE, 0, 0,          0,          0, 1'b0);
    add_beat(OP_READ,  1, 9,          0,          0, 1'b0);
    add_beat(OP_CLOSE, 2, 0,          0,          0, 1'b0);
    add_beat(OP_OPEN,  3, 0,          25'h0AAAAAA, 0, 1'b0);

    // random: mostly reads from a small page pool so hits and evictions both occur
    for (int i = 0; i < 600; i++) begin
      f    = $urandom_range(0, 3);
      roll = $urandom_range(0, 99);
      if (roll < 74)      op = OP_READ;
      else if (roll < 86) op = OP_WRITE;
      else if (roll < 96) op = OP_OPEN;
      else                op = OP_CLOSE;
      roll = $urandom_range(0, 99);
      pg   = (roll < 88) ? $urandom_range(0, 23) : $urandom_range(0, 24'hFFFFFF);
      roll = $urandom_range(0, 99);
      if (roll < 70)      cnt = $urandom_range(8, 32);
      else if (roll < 90) cnt = $urandom_range(0, 25'h1000000);
      else                cnt = 25'h1000000;
      add_beat(op, f, pg, cnt, i / 200, (i % 150) == 0);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (pending.size() != 0 || req_if.valid || expected_rsp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mism_cnt == 0 && expected_rsp.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

endmodule
